// File: rtl/dvr_pkg.sv
// Shared types, constants and lane functions for the dual velocity ramp generator.
package dvr_pkg;

    localparam int ValW  = 32;
    localparam int LimW  = 31;
    localparam int DtW   = 16;
    localparam int DiffW = ValW + 1;
    localparam int SumW  = ValW + 2;
    localparam int ProdW = LimW + DtW;
    localparam int AddrW = 4;
    localparam int DataW = 32;

    typedef logic signed [ValW-1:0] val_t;
    typedef logic [LimW-1:0]        lim_t;
    typedef logic [DtW-1:0]         dt_t;

    localparam val_t ValMax = {1'b0, {(ValW-1){1'b1}}};
    localparam val_t ValMin = {1'b1, {(ValW-1){1'b0}}};

    // Register map, word index into the APB space
    typedef enum logic [1:0] {
        REG_LIN_ACCEL = 2'd0,
        REG_LIN_DECEL = 2'd1,
        REG_ANG_ACCEL = 2'd2,
        REG_ANG_DECEL = 2'd3
    } reg_idx_t;

    // Item kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_ENABLE = 1'b1;

    // Input item as held in the input register
    typedef struct packed {
        logic kind;
        val_t lin_target;
        val_t ang_target;
        val_t lin_measured;
        val_t ang_measured;
        dt_t  step_time;
    } item_t;

    // Per-lane step: direction toward target and step magnitude
    typedef struct packed {
        logic pos;
        logic neg;
        lim_t step;
    } lane_step_t;

    // Stage-two payload for one lane
    typedef struct packed {
        val_t       target;
        val_t       measured;
        lane_step_t st;
    } lane_mid_t;

    // Direction and limit selection, then limit*dt truncated to Q16.16
    function automatic lane_step_t lane_prep(val_t t, val_t m, lim_t acc, lim_t dec, dt_t dt);
        logic signed [DiffW-1:0] d;
        logic                    use_dec;
        lim_t                    lim;
        logic [ProdW-1:0]        prod;
        lane_step_t              res;
        d       = DiffW'(t) - DiffW'(m);
        res.pos = !d[DiffW-1] && (d != '0);
        res.neg = d[DiffW-1];
        // measurement moving toward zero picks the decel limit
        use_dec = (m != '0) && (d != '0) && (m[ValW-1] != d[DiffW-1]);
        lim     = use_dec ? dec : acc;
        prod    = ProdW'(lim) * ProdW'(dt);
        res.step = prod[ProdW-1:DtW];
        return res;
    endfunction

    // Restart, step with saturation, then clamp at the target
    function automatic val_t lane_update(lane_mid_t x, val_t r);
        logic signed [DiffW-1:0] dmr;
        logic signed [DiffW-1:0] dtr;
        logic signed [DiffW-1:0] dt2;
        logic signed [SumW-1:0]  sum;
        logic                    restart;
        logic                    clamp;
        val_t                    r1;
        val_t                    r2;
        dmr     = DiffW'(x.measured) - DiffW'(r);
        dtr     = DiffW'(x.target) - DiffW'(r);
        restart = (dmr != '0) && (dtr != '0) && (dmr[DiffW-1] == dtr[DiffW-1]);
        r1      = restart ? x.measured : r;
        if (x.st.pos)
            sum = SumW'(r1) + $signed(SumW'(x.st.step));
        else if (x.st.neg)
            sum = SumW'(r1) - $signed(SumW'(x.st.step));
        else
            sum = SumW'(r1);
        // saturate to the signed 32-bit range
        if ((sum[SumW-1:ValW-1] == '0) || (sum[SumW-1:ValW-1] == '1))
            r2 = sum[ValW-1:0];
        else
            r2 = sum[SumW-1] ? ValMin : ValMax;
        dt2   = DiffW'(x.target) - DiffW'(r2);
        clamp = (x.st.pos && dt2[DiffW-1]) ||
                (x.st.neg && !dt2[DiffW-1] && (dt2 != '0));
        return clamp ? x.target : r2;
    endfunction

endpackage

// File: rtl/dvr_in_if.sv
// Input channel: valid/ready handshake with one tick or enable item.
interface dvr_in_if
    import dvr_pkg::*;
();
    logic valid;
    logic ready;
    logic kind;
    val_t lin_target;
    val_t ang_target;
    val_t lin_measured;
    val_t ang_measured;
    dt_t  step_time;

    modport source (output valid, kind, lin_target, ang_target, lin_measured,
                    ang_measured, step_time, input ready);
    modport sink   (input valid, kind, lin_target, ang_target, lin_measured,
                    ang_measured, step_time, output ready);
endinterface

// File: rtl/dvr_out_if.sv
// Output channel: valid/ready handshake with the two ramp setpoints.
interface dvr_out_if
    import dvr_pkg::*;
();
    logic valid;
    logic ready;
    val_t lin_ramp_out;
    val_t ang_ramp_out;

    modport source (output valid, lin_ramp_out, ang_ramp_out, input ready);
    modport sink   (input valid, lin_ramp_out, ang_ramp_out, output ready);
endinterface

// File: rtl/dual_velocity_ramp_generator.sv
// An item goes from the input register to the result register; the ramp state is read and written
// only at the result register. Throughput: one item per cycle while the result is not stalled.
// The step multiply (31x16 per lane) and the ramp add sit together between the two registers.
// Input stalls only while both registers hold items and the result is not taken.
// Reset (rst_n low, async) clears valids, limit registers and both ramps to zero.
module dual_velocity_ramp_generator
    import dvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dvr_in_if.sink           in_ch,
    dvr_out_if.source        out_ch,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    lim_t lin_acc_reg;
    lim_t lin_dec_reg;
    lim_t ang_acc_reg;
    lim_t ang_dec_reg;

    logic      s1_valid_reg;
    item_t     s1_item_reg;
    logic      out_valid_reg;
    val_t      lin_ramp_reg;
    val_t      ang_ramp_reg;

    logic      out_move;
    logic      s1_move;
    logic      in_fire;
    reg_idx_t  reg_idx;
    logic      cfg_wr;
    val_t      lin_ramp_next;
    val_t      ang_ramp_next;
    lane_mid_t lin_mid_next;
    lane_mid_t ang_mid_next;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_acc_reg <= '0;
            lin_dec_reg <= '0;
            ang_acc_reg <= '0;
            ang_dec_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_LIN_ACCEL: lin_acc_reg <= pwdata[LimW-1:0];
                REG_LIN_DECEL: lin_dec_reg <= pwdata[LimW-1:0];
                REG_ANG_ACCEL: ang_acc_reg <= pwdata[LimW-1:0];
                REG_ANG_DECEL: ang_dec_reg <= pwdata[LimW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LIN_ACCEL: prdata = DataW'(lin_acc_reg);
            REG_LIN_DECEL: prdata = DataW'(lin_dec_reg);
            REG_ANG_ACCEL: prdata = DataW'(ang_acc_reg);
            REG_ANG_DECEL: prdata = DataW'(ang_dec_reg);
        endcase
    end

    // Pipeline flow: a stage moves when the next one is empty or moving
    assign out_move     = !out_valid_reg || out_ch.ready;
    assign s1_move      = !s1_valid_reg || out_move;
    assign in_ch.ready  = s1_move;
    assign in_fire      = in_ch.valid && in_ch.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_move)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.kind         <= in_ch.kind;
            s1_item_reg.lin_target   <= in_ch.lin_target;
            s1_item_reg.ang_target   <= in_ch.ang_target;
            s1_item_reg.lin_measured <= in_ch.lin_measured;
            s1_item_reg.ang_measured <= in_ch.ang_measured;
            s1_item_reg.step_time    <= in_ch.step_time;
        end
    end

    // Step: direction, limit choice and limit*dt per lane
    always_comb
    begin
        lin_mid_next.target   = s1_item_reg.lin_target;
        lin_mid_next.measured = s1_item_reg.lin_measured;
        lin_mid_next.st       = lane_prep(s1_item_reg.lin_target, s1_item_reg.lin_measured,
                                          lin_acc_reg, lin_dec_reg, s1_item_reg.step_time);
        ang_mid_next.target   = s1_item_reg.ang_target;
        ang_mid_next.measured = s1_item_reg.ang_measured;
        ang_mid_next.st       = lane_prep(s1_item_reg.ang_target, s1_item_reg.ang_measured,
                                          ang_acc_reg, ang_dec_reg, s1_item_reg.step_time);
    end

    // Ramp update: restart, step, saturate, clamp; enable clears both
    always_comb
    begin
        if (s1_item_reg.kind == KIND_ENABLE)
        begin
            lin_ramp_next = '0;
            ang_ramp_next = '0;
        end
        else
        begin
            lin_ramp_next = lane_update(lin_mid_next, lin_ramp_reg);
            ang_ramp_next = lane_update(ang_mid_next, ang_ramp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lin_ramp_reg  <= '0;
            ang_ramp_reg  <= '0;
        end
        else
        begin
            if (out_move)
                out_valid_reg <= s1_valid_reg;
            if (out_move && s1_valid_reg)
            begin
                lin_ramp_reg <= lin_ramp_next;
                ang_ramp_reg <= ang_ramp_next;
            end
        end
    end

    // The ramp registers double as the result register
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.lin_ramp_out = lin_ramp_reg;
    assign out_ch.ang_ramp_out = ang_ramp_reg;

    // Checks
    a_enable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_move && (s1_item_reg.kind == KIND_ENABLE))
            |=> (lin_ramp_reg == '0) && (ang_ramp_reg == '0))
        else $error("enable item did not clear ramps");

    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_move) |=> out_valid_reg)
        else $error("item lost between input register and output");

    a_ramp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> $stable(lin_ramp_reg) && $stable(ang_ramp_reg))
        else $error("ramp state changed while result stalled");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline slot");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the dual velocity ramp generator: stimulus table, random items.
`timescale 1ns / 100ps
module testbench;
    import dvr_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int HoldCycles    = 300;
    localparam int RandPhases    = 8;
    localparam int PhaseItems    = 180;
    localparam int ReportMax     = 10;
    localparam int DirRows       = 15;

    typedef struct packed {
        val_t lin;
        val_t ang;
    } ramp_pair_t;

    // One row of the directed stimulus table
    typedef struct packed {
        logic set_max_lim;
        logic kind;
        val_t lin_t;
        val_t ang_t;
        val_t lin_m;
        val_t ang_m;
        dt_t  dt;
        logic typed;
        val_t lin_exp;
        val_t ang_exp;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    dvr_in_if  in_ch ();
    dvr_out_if out_ch ();

    // Predictor state: limit registers and both ramps
    lim_t lim_reg [4];
    val_t lin_ramp_st;
    val_t ang_ramp_st;
    val_t lin_goal;
    val_t ang_goal;

    ramp_pair_t ramp_expect_q [$];
    int         err_cnt;
    int         idle_cycles;
    int         in_idle_pct;
    int         out_stall_pct;
    bit         hold_req;
    int         hold_left;

    // Directed items: reset state, restart, overshoot clamp, saturation, equal target, enable
    dir_row_t dir_rows [DirRows] = '{
        '{1'b0, KIND_TICK, 32'sd100, -32'sd5, 32'sd0, 32'sd0, 16'hFFFF,
          1'b1, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, 32'sd100, -32'sd100, 32'sd50, -32'sd50, 16'hFFFF,
          1'b1, 32'sd50, -32'sd50},
        '{1'b0, KIND_ENABLE, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 16'h0000,
          1'b1, 32'sd0, 32'sd0},
        '{1'b1, KIND_TICK, 32'sd100, -32'sd100, 32'sd0, 32'sd0, 16'hFFFF,
          1'b1, 32'sd100, -32'sd100},
        '{1'b0, KIND_TICK, ValMax, ValMin, ValMax - 32'sd10, ValMin + 32'sd10, 16'hFFFF,
          1'b1, ValMax, ValMin},
        '{1'b0, KIND_TICK, 32'sd1234, 32'sd1234, 32'sd1234, 32'sd1234, 16'hFFFF,
          1'b1, 32'sd1234, 32'sd1234},
        '{1'b0, KIND_TICK, ValMin, ValMax, 32'sd0, 32'sd0, 16'h0000,
          1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, 32'sd0, 32'sd0, 32'sh0005_0000, -32'sh0005_0000, 16'h8000,
          1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_ENABLE, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'hFFFF,
          1'b1, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, ValMin, ValMin, ValMax, ValMax, 16'hFFFF,
          1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, ValMax, ValMax, ValMin, ValMin, 16'h0001,
          1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 16'h0001,
          1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, 32'sh0003_0000, -32'sh0003_0000, 32'sh0001_0000,
          -32'sh0001_0000, 16'h1234, 1'b0, 32'sd0, 32'sd0},
        '{1'b0, KIND_ENABLE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000,
          1'b1, 32'sd0, 32'sd0},
        '{1'b0, KIND_TICK, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
          32'sh5555_5555, 16'hAAAA, 1'b0, 32'sd0, 32'sd0}
    };

    dual_velocity_ramp_generator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int sgn(longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    // One lane: restart at measurement, limited step, saturate, clamp at target
    function automatic val_t step_lane(val_t tgt, val_t meas, val_t ramp,
                                       lim_t acc, lim_t dec, dt_t dt);
        longint t;
        longint m;
        longint r;
        longint lim;
        longint mag;
        int     dir;
        t = tgt;
        m = meas;
        r = ramp;
        if (sgn(m - r) * sgn(t - r) > 0)
            r = m;
        dir = sgn(t - m);
        // measurement heading toward zero uses the decel limit
        lim = (sgn(m) * dir >= 0) ? longint'(acc) : longint'(dec);
        mag = (lim * longint'(dt)) >> 16;
        r   = r + dir * mag;
        if (r > longint'(ValMax))
            r = ValMax;
        if (r < longint'(ValMin))
            r = ValMin;
        if (dir * sgn(t - r) < 0)
            r = t;
        return val_t'(r);
    endfunction

    // Advance the ramp state by one accepted item
    function automatic ramp_pair_t ramp_predict(item_t it);
        ramp_pair_t p;
        if (it.kind == KIND_ENABLE)
        begin
            lin_ramp_st = '0;
            ang_ramp_st = '0;
        end
        else
        begin
            lin_ramp_st = step_lane(it.lin_target, it.lin_measured, lin_ramp_st,
                                    lim_reg[REG_LIN_ACCEL], lim_reg[REG_LIN_DECEL],
                                    it.step_time);
            ang_ramp_st = step_lane(it.ang_target, it.ang_measured, ang_ramp_st,
                                    lim_reg[REG_ANG_ACCEL], lim_reg[REG_ANG_DECEL],
                                    it.step_time);
        end
        p.lin = lin_ramp_st;
        p.ang = ang_ramp_st;
        return p;
    endfunction

    // Velocity values: mostly near the ramp or small, some extremes and full range
    function automatic val_t pick_val(val_t near);
        case ($urandom_range(0, 9))
            0: return val_t'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return ValMax;
                    1: return ValMin;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            2, 3, 4: return near + val_t'($urandom_range(0, 32'h0004_0000))
                            - val_t'(32'h0002_0000);
            5: return near;
            default: return val_t'($urandom_range(0, 32'h0080_0000))
                            - val_t'(32'h0040_0000);
        endcase
    endfunction

    // Targets are held over several ticks so the ramp gets to converge
    function automatic item_t rand_item();
        item_t it;
        if ($urandom_range(0, 9) == 0)
            lin_goal = pick_val(lin_ramp_st);
        if ($urandom_range(0, 9) == 0)
            ang_goal = pick_val(ang_ramp_st);
        it.kind         = ($urandom_range(0, 39) == 0) ? KIND_ENABLE : KIND_TICK;
        it.lin_target   = lin_goal;
        it.ang_target   = ang_goal;
        it.lin_measured = pick_val(lin_ramp_st);
        it.ang_measured = pick_val(ang_ramp_st);
        case ($urandom_range(0, 9))
            0: it.step_time = dt_t'($urandom);
            1: it.step_time = $urandom_range(0, 1) ? '1 : '0;
            default: it.step_time = dt_t'($urandom_range(0, 16'h0400));
        endcase
        return it;
    endfunction

    function automatic logic [DataW-1:0] rand_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    // Offer one item, wait for acceptance, then record its expected result
    task automatic send_item(input item_t it, input logic use_typed,
                             input ramp_pair_t typed_exp);
        ramp_pair_t p;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= it.kind;
        in_ch.lin_target   <= it.lin_target;
        in_ch.ang_target   <= it.ang_target;
        in_ch.lin_measured <= it.lin_measured;
        in_ch.ang_measured <= it.ang_measured;
        in_ch.step_time    <= it.step_time;
        do
            @(posedge clk);
        while (!in_ch.ready);
        p = ramp_predict(it);
        if (use_typed)
            p = typed_exp;
        ramp_expect_q.push_back(p);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_limit(input reg_idx_t idx, input logic [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lim_reg[idx] = value[LimW-1:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (ramp_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(input val_t lin, input val_t ang);
        ramp_pair_t e;
        if (ramp_expect_q.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= ReportMax)
                $display("unexpected result: lin_ramp_out=%0d ang_ramp_out=%0d", lin, ang);
        end
        else
        begin
            e = ramp_expect_q.pop_front();
            if (e.lin !== lin)
            begin
                err_cnt++;
                if (err_cnt <= ReportMax)
                    $display("lin_ramp_out error: expected %0d got %0d", e.lin, lin);
            end
            if (e.ang !== ang)
            begin
                err_cnt++;
                if (err_cnt <= ReportMax)
                    $display("ang_ramp_out error: expected %0d got %0d", e.ang, ang);
            end
        end
    endtask

    // Result side: check accepted items, drive ready with stalls and hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.lin_ramp_out, out_ch.ang_ramp_out);
            if (hold_req)
            begin
                hold_left = HoldCycles;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence
    initial
    begin
        item_t      it;
        ramp_pair_t typed_exp;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_TICK;
        in_ch.lin_target   <= '0;
        in_ch.ang_target   <= '0;
        in_ch.lin_measured <= '0;
        in_ch.ang_measured <= '0;
        in_ch.step_time    <= '0;
        for (int r = 0; r < 4; r++)
            lim_reg[r] = '0;
        lin_ramp_st   = '0;
        ang_ramp_st   = '0;
        lin_goal      = '0;
        ang_goal      = '0;
        err_cnt       = 0;
        idle_cycles   = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DirRows; i++)
        begin
            if (dir_rows[i].set_max_lim)
            begin
                drain();
                for (int r = 0; r < 4; r++)
                    write_limit(reg_idx_t'(r), 32'hFFFF_FFFF);
            end
            it.kind         = dir_rows[i].kind;
            it.lin_target   = dir_rows[i].lin_t;
            it.ang_target   = dir_rows[i].ang_t;
            it.lin_measured = dir_rows[i].lin_m;
            it.ang_measured = dir_rows[i].ang_m;
            it.step_time    = dir_rows[i].dt;
            typed_exp.lin   = dir_rows[i].lin_exp;
            typed_exp.ang   = dir_rows[i].ang_exp;
            send_item(it, dir_rows[i].typed, typed_exp);
        end

        // Random phases, each with new limits and an idling mix set by the phase number
        for (int ph = 0; ph < RandPhases; ph++)
        begin
            drain();
            for (int r = 0; r < 4; r++)
                write_limit(reg_idx_t'(r), (ph == 2) ? 32'h0 :
                                           (ph == 5) ? 32'h7FFF_FFFF : rand_limit());
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 70; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 70; end
                default: begin in_idle_pct = 10; out_stall_pct = 10; end
            endcase
            // long receiver hold-off while items keep coming
            if (ph == 0)
                hold_req = 1'b1;
            repeat (PhaseItems)
                send_item(rand_item(), 1'b0, '0);
        end

        drain();
        repeat (6) @(posedge clk);
        if (err_cnt == 0 && ramp_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
